>>> rtl/fwgr_pkg.sv
// Shared types and constants for the full-weighting grid restriction block.
// No dependencies; fwgr_scan, fwgr_datapath and the top level import this package.
package fwgr_pkg;

   localparam int SAMPLE_BITS     = 32;
   localparam int VALUE_BITS      = SAMPLE_BITS + 2;
   localparam int SUM_BITS        = SAMPLE_BITS + 2;
   localparam int ACC_BITS        = SAMPLE_BITS + 5;
   localparam int MAX_COARSE_SIDE = 512;
   localparam int SIDE_BITS       = $clog2(MAX_COARSE_SIDE) + 1;
   localparam int COORD_BITS      = $clog2(MAX_COARSE_SIDE);
   localparam int ROW_DEPTH       = 2 * MAX_COARSE_SIDE;
   localparam int ADDR_BITS       = $clog2(ROW_DEPTH);
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = SIDE_BITS;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_ONE_DIM_MODE  = 3'd0,
      CSR_COARSE_WIDTH  = 3'd1,
      CSR_COARSE_HEIGHT = 3'd2,
      CSR_DEFECT_MODE   = 3'd3,
      CSR_NEUMANN_FIRST = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_CORNER,
      KIND_ROW_EDGE,
      KIND_COL_EDGE,
      KIND_INTERIOR,
      KIND_LINE
   } kind_type;

   typedef struct packed {
      logic                 one_dim;
      logic [SIDE_BITS-1:0] cw;
      logic [SIDE_BITS-1:0] ch;
      logic                 defect;
      logic                 neumann;
   } cfg_type;

   typedef struct packed {
      logic                  hit;
      kind_type              kind;
      logic                  rc_last;
      logic                  cc_last;
      logic [COORD_BITS-1:0] i;
      logic [COORD_BITS-1:0] j;
      logic                  done;
   } node_type;

endpackage

>>> rtl/fwgr_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module fwgr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/fwgr_scan.sv
// Fine-grid raster counters and per-sample node classification.
// Depends on fwgr_pkg.
module fwgr_scan import fwgr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 restart,
   input  logic                 advance,
   output logic [ADDR_BITS-1:0] fine_x,
   output node_type             node
);

   logic [ADDR_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic [SIDE_BITS:0]    fw_m1_w, fh_m1_w;
   logic [ADDR_BITS-1:0]  fw_m1, fh_m1;
   logic [SIDE_BITS-1:0]  cw_m1, ch_m1;
   logic                  last_col, last_row, col_hit, row_hit;
   logic                  i_first, i_edge, j_first, j_edge;

   assign fw_m1_w = {cfg.cw, 1'b0} - (SIDE_BITS + 1)'(2);
   assign fh_m1_w = {cfg.ch, 1'b0} - (SIDE_BITS + 1)'(2);
   assign fw_m1   = fw_m1_w[ADDR_BITS-1:0];
   assign fh_m1   = fh_m1_w[ADDR_BITS-1:0];
   assign cw_m1   = cfg.cw - SIDE_BITS'(1);
   assign ch_m1   = cfg.ch - SIDE_BITS'(1);

   assign last_col = (x_ff == fw_m1);
   assign last_row = (y_ff == fh_m1);
   assign col_hit  = last_col | x_ff[0];
   assign row_hit  = cfg.one_dim | last_row | y_ff[0];

   always_comb begin
      node.hit     = col_hit & row_hit;
      node.i       = last_col ? cw_m1[COORD_BITS-1:0] : x_ff[ADDR_BITS-1:1];
      if (cfg.one_dim) begin
         node.j    = '0;
      end else begin
         node.j    = last_row ? ch_m1[COORD_BITS-1:0] : y_ff[ADDR_BITS-1:1];
      end
      i_first      = (node.i == '0);
      i_edge       = i_first | last_col;
      j_first      = (node.j == '0);
      j_edge       = j_first | last_row;
      node.cc_last = last_col;
      node.rc_last = cfg.one_dim | last_row;
      node.done    = last_col & (cfg.one_dim | last_row);
      if (cfg.one_dim) begin
         node.kind = i_edge ? KIND_CORNER : KIND_LINE;
      end else if (i_edge && j_edge) begin
         node.kind = KIND_CORNER;
      end else if (j_edge) begin
         node.kind = KIND_ROW_EDGE;
      end else if (i_edge) begin
         node.kind = KIND_COL_EDGE;
      end else begin
         node.kind = KIND_INTERIOR;
      end
   end

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (restart) begin
         x_in = '0;
         y_in = '0;
      end else if (advance) begin
         if (x_ff >= fw_m1) begin
            x_in = '0;
            y_in = (cfg.one_dim || y_ff >= fh_m1) ? '0 : y_ff + ADDR_BITS'(1);
         end else begin
            x_in = x_ff + ADDR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign fine_x = x_ff;

   a_x_in_row: assert property (@(posedge clock) disable iff (reset)
      x_ff <= fw_m1) else $error("fine column beyond row end");
   a_line_row_zero: assert property (@(posedge clock) disable iff (reset)
      cfg.one_dim |-> (y_ff == '0)) else $error("row count moved in line mode");

endmodule

>>> rtl/fwgr_datapath.sv
// Stencil datapath: sliding windows, partial-sum stage and output register.
// Depends on fwgr_pkg.
module fwgr_datapath import fwgr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_b,
   input  logic                          load_c,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  logic signed [SAMPLE_BITS-1:0] prev,
   input  logic signed [SAMPLE_BITS-1:0] prev2,
   input  node_type                      node,
   input  cfg_type                       cfg,
   output logic signed [VALUE_BITS-1:0]  coarse_value,
   output logic [COORD_BITS-1:0]         coarse_x,
   output logic [COORD_BITS-1:0]         coarse_y,
   output logic                          grid_done
);

   function automatic logic signed [SUM_BITS-1:0] tap3(
      input logic signed [SAMPLE_BITS-1:0] a,
      input logic signed [SAMPLE_BITS-1:0] b,
      input logic signed [SAMPLE_BITS-1:0] c
   );
      tap3 = SUM_BITS'(a) + (SUM_BITS'(b) <<< 1) + SUM_BITS'(c);
   endfunction

   // Index 0 is column x-1, index 1 is column x-2.
   logic signed [SAMPLE_BITS-1:0] left_ff [2];
   logic signed [SAMPLE_BITS-1:0] above_ff [2];
   logic signed [SAMPLE_BITS-1:0] above2_ff [2];

   logic signed [SUM_BITS-1:0]    rs0_in, rs1_in, rs2_in, edge_in;
   logic signed [SAMPLE_BITS-1:0] corner_in;
   logic signed [SUM_BITS-1:0]    rs0_ff, rs1_ff, rs2_ff, edge_ff;
   logic signed [SAMPLE_BITS-1:0] corner_ff;
   kind_type                      kind_ff;
   logic [COORD_BITS-1:0]         i_ff, j_ff;
   logic                          done_ff;

   logic signed [ACC_BITS-1:0]    acc, shifted;
   logic                          cof2;
   logic signed [VALUE_BITS-1:0]  value_in, value_ff;
   logic [COORD_BITS-1:0]         x_out_ff, y_out_ff;
   logic                          done_out_ff;

   always_comb begin
      rs0_in = tap3(above2_ff[1], above2_ff[0], prev2);
      rs1_in = tap3(above_ff[1], above_ff[0], prev);
      rs2_in = tap3(left_ff[1], left_ff[0], sample);
      if (node.kind == KIND_ROW_EDGE) begin
         edge_in = node.rc_last ? rs2_in : rs1_in;
      end else if (node.cc_last) begin
         edge_in = tap3(prev2, prev, sample);
      end else begin
         edge_in = tap3(above2_ff[0], above_ff[0], left_ff[0]);
      end
      if (node.rc_last) begin
         corner_in = node.cc_last ? sample : left_ff[0];
      end else begin
         corner_in = node.cc_last ? prev : above_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff[0]   <= '0;
         left_ff[1]   <= '0;
         above_ff[0]  <= '0;
         above_ff[1]  <= '0;
         above2_ff[0] <= '0;
         above2_ff[1] <= '0;
      end else if (load_b) begin
         left_ff[1]   <= left_ff[0];
         left_ff[0]   <= sample;
         above_ff[1]  <= above_ff[0];
         above_ff[0]  <= prev;
         above2_ff[1] <= above2_ff[0];
         above2_ff[0] <= prev2;
      end
   end

   always_ff @(posedge clock) begin
      if (load_b && node.hit) begin
         rs0_ff    <= rs0_in;
         rs1_ff    <= rs1_in;
         rs2_ff    <= rs2_in;
         edge_ff   <= edge_in;
         corner_ff <= corner_in;
         kind_ff   <= node.kind;
         i_ff      <= node.i;
         j_ff      <= node.j;
         done_ff   <= node.done;
      end
   end

   assign cof2 = cfg.defect & cfg.neumann;

   // Arithmetic right shift floors, matching the stencil rounding.
   always_comb begin
      acc     = '0;
      shifted = '0;
      case (kind_ff)
         KIND_CORNER: begin
            acc     = ACC_BITS'(corner_ff);
            shifted = cof2 ? (acc <<< 1) : acc;
         end
         KIND_ROW_EDGE, KIND_COL_EDGE: begin
            acc     = cof2 ? (ACC_BITS'(edge_ff) <<< 1) : ACC_BITS'(edge_ff);
            shifted = acc >>> 2;
         end
         KIND_INTERIOR: begin
            acc     = ACC_BITS'(rs0_ff) + (ACC_BITS'(rs1_ff) <<< 1) + ACC_BITS'(rs2_ff);
            shifted = cfg.defect ? (acc >>> 2) : (acc >>> 4);
         end
         KIND_LINE: begin
            acc     = ACC_BITS'(rs2_ff);
            shifted = cfg.defect ? acc : (acc >>> 2);
         end
         default: begin
            acc     = '0;
            shifted = '0;
         end
      endcase
      value_in = shifted[VALUE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (load_c) begin
         value_ff    <= value_in;
         x_out_ff    <= i_ff;
         y_out_ff    <= j_ff;
         done_out_ff <= done_ff;
      end
   end

   assign coarse_value = value_ff;
   assign coarse_x     = x_out_ff;
   assign coarse_y     = y_out_ff;
   assign grid_done    = done_out_ff;

endmodule

>>> rtl/full_weighting_grid_restriction.sv
// Top level of the full-weighting grid restriction: config registers, pipeline
// control and the row store. Depends on fwgr_pkg, fwgr_ram, fwgr_scan, fwgr_datapath.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/ready    fine_sample (32b signed Q16.16)
//   rsp_        out        rsp_valid/ready    coarse_value, coarse_x, coarse_y, grid_done
//   csr_        in         csr_wen            csr_index, csr_wdata
//
// One fine sample is taken per cycle unless a stalled output has filled the pipeline;
// a node's result passes the row-store read, partial sums and final sum, then leaves.
// Both fine rows above live in one 1024 x 64 row store, read at accept and written
// back as stage A moves on; the single write port sets the one-per-cycle rate.
// Reset is synchronous and clears control, counters and windows; the row store
// needs no clearing. A stalled output fills the pipeline before req_ready drops.
module full_weighting_grid_restriction import fwgr_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_fine_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [VALUE_BITS-1:0]  rsp_coarse_value,
   output logic [COORD_BITS-1:0]         rsp_coarse_x,
   output logic [COORD_BITS-1:0]         rsp_coarse_y,
   output logic                          rsp_grid_done,
   input  logic                          csr_wen,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   logic                          one_dim_ff, defect_ff, neumann_ff;
   logic [SIDE_BITS-1:0]          cw_raw_ff, ch_raw_ff;
   logic [SIDE_BITS-1:0]          cw_clamped, ch_clamped;
   cfg_type                       cfg;
   logic                          restart;

   logic                          accept;
   logic                          va_ff, vb_ff, vc_ff;
   logic                          en_a, en_b, en_c;
   logic                          a_fire, c_load;
   logic signed [SAMPLE_BITS-1:0] sample_a_ff;
   node_type                      node_a_ff, node_scan;
   logic [ADDR_BITS-1:0]          addr_a_ff, fine_x;
   logic [2*SAMPLE_BITS-1:0]      ram_rdata, ram_wdata;
   logic signed [SAMPLE_BITS-1:0] rd_prev, rd_prev2;

   // Configuration registers; geometry writes restart the raster.
   always_ff @(posedge clock) begin
      if (reset) begin
         one_dim_ff <= 1'b0;
         cw_raw_ff  <= SIDE_BITS'(MAX_COARSE_SIDE);
         ch_raw_ff  <= SIDE_BITS'(MAX_COARSE_SIDE);
         defect_ff  <= 1'b1;
         neumann_ff <= 1'b0;
      end else if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_ONE_DIM_MODE:  one_dim_ff <= csr_wdata[0];
            CSR_COARSE_WIDTH:  cw_raw_ff  <= csr_wdata;
            CSR_COARSE_HEIGHT: ch_raw_ff  <= csr_wdata;
            CSR_DEFECT_MODE:   defect_ff  <= csr_wdata[0];
            CSR_NEUMANN_FIRST: neumann_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      restart = 1'b0;
      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_ONE_DIM_MODE, CSR_COARSE_WIDTH, CSR_COARSE_HEIGHT: restart = 1'b1;
            default: restart = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (cw_raw_ff < SIDE_BITS'(2)) begin
         cw_clamped = SIDE_BITS'(2);
      end else if (cw_raw_ff > SIDE_BITS'(MAX_COARSE_SIDE)) begin
         cw_clamped = SIDE_BITS'(MAX_COARSE_SIDE);
      end else begin
         cw_clamped = cw_raw_ff;
      end
      if (ch_raw_ff < SIDE_BITS'(2)) begin
         ch_clamped = SIDE_BITS'(2);
      end else if (ch_raw_ff > SIDE_BITS'(MAX_COARSE_SIDE)) begin
         ch_clamped = SIDE_BITS'(MAX_COARSE_SIDE);
      end else begin
         ch_clamped = ch_raw_ff;
      end
      cfg.one_dim = one_dim_ff;
      cfg.cw      = cw_clamped;
      cfg.ch      = ch_clamped;
      cfg.defect  = defect_ff;
      cfg.neumann = neumann_ff;
   end

   // Pipeline control: stage A waits on row-store data, B holds partial sums,
   // C is the output register. Non-hit samples leave after stage A.
   assign en_c      = ~vc_ff | rsp_ready;
   assign en_b      = ~vb_ff | en_c;
   assign en_a      = ~va_ff | en_b;
   assign req_ready = en_a;
   assign accept    = req_valid & en_a;
   assign a_fire    = va_ff & en_b;
   assign c_load    = vb_ff & en_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= req_valid;
         end
         if (en_b) begin
            vb_ff <= a_fire & node_a_ff.hit;
         end
         if (en_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_a_ff <= req_fine_sample;
         node_a_ff   <= node_scan;
         addr_a_ff   <= fine_x;
      end
   end

   fwgr_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .restart (restart),
      .advance (accept),
      .fine_x  (fine_x),
      .node    (node_scan)
   );

   // Row store entry: upper half is row y-1, lower half is row y-2.
   assign rd_prev   = ram_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
   assign rd_prev2  = ram_rdata[SAMPLE_BITS-1:0];
   assign ram_wdata = {sample_a_ff, rd_prev};

   fwgr_ram #(
      .WIDTH (2 * SAMPLE_BITS),
      .DEPTH (ROW_DEPTH)
   ) u_row_store (
      .clock (clock),
      .we    (a_fire),
      .waddr (addr_a_ff),
      .wdata (ram_wdata),
      .re    (accept),
      .raddr (fine_x),
      .rdata (ram_rdata)
   );

   fwgr_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .load_b       (a_fire),
      .load_c       (c_load),
      .sample       (sample_a_ff),
      .prev         (rd_prev),
      .prev2        (rd_prev2),
      .node         (node_a_ff),
      .cfg          (cfg),
      .coarse_value (rsp_coarse_value),
      .coarse_x     (rsp_coarse_x),
      .coarse_y     (rsp_coarse_y),
      .grid_done    (rsp_grid_done)
   );

   assign rsp_valid = vc_ff;

   a_hold_read_data: assert property (@(posedge clock) disable iff (reset)
      (va_ff && !en_b) |-> !accept) else $error("row store read while stage A stalled");
   a_accept_fills_a: assert property (@(posedge clock) disable iff (reset)
      accept |=> va_ff) else $error("accepted sample lost before stage A");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable({rsp_coarse_value, rsp_coarse_x,
                                                             rsp_coarse_y, rsp_grid_done})))
      else $error("waiting result changed before transfer");

endmodule

>>> tb/sv/full_weighting_grid_restriction_tb.sv
// Self-checking testbench for full_weighting_grid_restriction: streams fine grids
// through the block and checks every coarse node against an in-bench predictor.
// Depends on fwgr_pkg and the RTL of the block.
`timescale 1ns / 100ps

module full_weighting_grid_restriction_tb import fwgr_pkg::*; ();

   localparam int RANDOM_ITEMS = 920;

   typedef enum int {
      PACE_STEADY,
      PACE_LIGHT,
      PACE_HEAVY
   } pace_type;

   typedef struct {
      logic signed [VALUE_BITS-1:0] value;
      logic [COORD_BITS-1:0]        x;
      logic [COORD_BITS-1:0]        y;
      logic                         done;
   } coarse_node_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_fine_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [VALUE_BITS-1:0]  rsp_coarse_value;
   logic [COORD_BITS-1:0]         rsp_coarse_x;
   logic [COORD_BITS-1:0]         rsp_coarse_y;
   logic                          rsp_grid_done;
   logic                          csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_wdata = '0;

   // register copies and predictor state
   logic                          cfg_one_dim;
   logic [SIDE_BITS-1:0]          cfg_width;
   logic [SIDE_BITS-1:0]          cfg_height;
   logic                          cfg_defect;
   logic                          cfg_neumann;
   logic signed [SAMPLE_BITS-1:0] row_above [ROW_DEPTH];
   logic signed [SAMPLE_BITS-1:0] row_above2 [ROW_DEPTH];
   logic signed [SAMPLE_BITS-1:0] cur_left [2];
   logic signed [SAMPLE_BITS-1:0] up_left [2];
   logic signed [SAMPLE_BITS-1:0] up2_left [2];
   int unsigned                   fine_x;
   int unsigned                   fine_y;

   logic signed [SAMPLE_BITS-1:0] sample_queue [$];
   coarse_node_type               pending_nodes [$];
   coarse_node_type               oldest_node;
   pace_type                      send_pace = PACE_HEAVY;
   pace_type                      recv_pace = PACE_HEAVY;
   int                            send_gap;
   int                            rsp_stall;
   int                            mismatch_count = 0;
   int                            grid_items;
   int                            random_items;
   int                            burst;

   full_weighting_grid_restriction uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_fine_sample  (req_fine_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_coarse_value (rsp_coarse_value),
      .rsp_coarse_x     (rsp_coarse_x),
      .rsp_coarse_y     (rsp_coarse_y),
      .rsp_grid_done    (rsp_grid_done),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic int unsigned side_of(input logic [SIDE_BITS-1:0] v);
      if (v < 2)
         return 2;
      if (v > MAX_COARSE_SIDE)
         return MAX_COARSE_SIDE;
      return 32'(v);
   endfunction

   function automatic int draw_wait(input pace_type pace);
      case (pace)
         PACE_STEADY: return 0;
         PACE_LIGHT:  return $urandom_range(0, 3);
         default:     return $urandom_range(0, 18);
      endcase
   endfunction

   function automatic logic [CSR_DATA_BITS-1:0] draw_side();
      case ($urandom_range(0, 9))
         0:       return CSR_DATA_BITS'($urandom_range(0, 1));
         1:       return CSR_DATA_BITS'($urandom_range(9, 16));
         default: return CSR_DATA_BITS'($urandom_range(2, 6));
      endcase
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] draw_sample(input bit extreme_only);
      if (extreme_only)
         return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return $signed($urandom_range(0, 4096)) - 2048;
         default: return $urandom();
      endcase
   endfunction

   // Advance the predictor by one accepted fine sample; queue the node it completes.
   function automatic void restrict_sample(input logic signed [SAMPLE_BITS-1:0] fine_in);
      int unsigned     cw, ch, fw, fh, ci, rj, rc, cc;
      longint          g [3][3];
      longint          cof, val, t;
      bit              col_hit, row_hit, i_edge, j_edge;
      coarse_node_type node;
      cw = side_of(cfg_width);
      ch = side_of(cfg_height);
      fw = 2 * cw - 1;
      fh = 2 * ch - 1;
      g[0][0] = up2_left[1];
      g[0][1] = up2_left[0];
      g[0][2] = row_above2[fine_x];
      g[1][0] = up_left[1];
      g[1][1] = up_left[0];
      g[1][2] = row_above[fine_x];
      g[2][0] = cur_left[1];
      g[2][1] = cur_left[0];
      g[2][2] = fine_in;
      cof = (cfg_defect && cfg_neumann) ? 2 : 1;
      val = 0;
      ci = 0;
      rj = 0;
      col_hit = 1'b1;
      row_hit = 1'b1;
      if (fine_x == fw - 1)
         ci = cw - 1;
      else if (fine_x % 2 == 1)
         ci = (fine_x - 1) / 2;
      else
         col_hit = 1'b0;
      if (cfg_one_dim)
         rj = 0;
      else if (fine_y == fh - 1)
         rj = ch - 1;
      else if (fine_y % 2 == 1)
         rj = (fine_y - 1) / 2;
      else
         row_hit = 1'b0;

      if (col_hit && row_hit) begin
         i_edge = (ci == 0) || (ci == cw - 1);
         j_edge = (rj == 0) || (rj == ch - 1);
         rc = (rj == ch - 1) ? 2 : 1;
         cc = (ci == cw - 1) ? 2 : 1;
         if (cfg_one_dim) begin
            if (ci == 0)
               val = cof * g[2][1];
            else if (ci == cw - 1)
               val = cof * g[2][2];
            else begin
               t = g[2][0] + 2 * g[2][1] + g[2][2];
               val = cfg_defect ? t : (t >>> 2);
            end
         end else if (i_edge && j_edge) begin
            val = cof * g[rc][cc];
         end else if (j_edge) begin
            val = (cof * (g[rc][0] + 2 * g[rc][1] + g[rc][2])) >>> 2;
         end else if (i_edge) begin
            val = (cof * (g[0][cc] + 2 * g[1][cc] + g[2][cc])) >>> 2;
         end else begin
            t = g[0][0] + 2 * g[0][1] + g[0][2]
              + 2 * g[1][0] + 4 * g[1][1] + 2 * g[1][2]
              + g[2][0] + 2 * g[2][1] + g[2][2];
            val = cfg_defect ? (t >>> 2) : (t >>> 4);
         end
         node.value = val[VALUE_BITS-1:0];
         node.x = ci[COORD_BITS-1:0];
         node.y = rj[COORD_BITS-1:0];
         node.done = (ci == cw - 1) && (cfg_one_dim || rj == ch - 1);
         pending_nodes = {pending_nodes, node};
      end

      // shift windows before the row stores are overwritten
      cur_left[1] = cur_left[0];
      cur_left[0] = fine_in;
      up_left[1] = up_left[0];
      up_left[0] = row_above[fine_x];
      up2_left[1] = up2_left[0];
      up2_left[0] = row_above2[fine_x];
      row_above2[fine_x] = row_above[fine_x];
      row_above[fine_x] = fine_in;

      if (fine_x >= fw - 1) begin
         fine_x = 0;
         if (cfg_one_dim || fine_y >= fh - 1)
            fine_y = 0;
         else
            fine_y = fine_y + 1;
      end else begin
         fine_x = fine_x + 1;
      end
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("%0t mismatch on %s: got %0d, want %0d", $time, what, got, want);
   endtask

   // Only called while idle; the bench copies of the registers follow the write.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_ONE_DIM_MODE:  cfg_one_dim = value[0];
         CSR_COARSE_WIDTH:  cfg_width = value;
         CSR_COARSE_HEIGHT: cfg_height = value;
         CSR_DEFECT_MODE:   cfg_defect = value[0];
         CSR_NEUMANN_FIRST: cfg_neumann = value[0];
         default: ;
      endcase
      if (idx == CSR_ONE_DIM_MODE || idx == CSR_COARSE_WIDTH || idx == CSR_COARSE_HEIGHT) begin
         fine_x = 0;
         fine_y = 0;
      end
   endtask

   task automatic set_geometry(input bit one_dim, input logic [CSR_DATA_BITS-1:0] w,
                               input logic [CSR_DATA_BITS-1:0] h, input bit defect,
                               input bit neumann);
      write_csr(CSR_ONE_DIM_MODE, CSR_DATA_BITS'(one_dim));
      write_csr(CSR_COARSE_WIDTH, w);
      write_csr(CSR_COARSE_HEIGHT, h);
      write_csr(CSR_DEFECT_MODE, CSR_DATA_BITS'(defect));
      write_csr(CSR_NEUMANN_FIRST, CSR_DATA_BITS'(neumann));
      grid_items = (2 * side_of(w) - 1) * (one_dim ? 1 : 2 * side_of(h) - 1);
   endtask

   task automatic load_samples(input int count, input bit extreme_only);
      repeat (count)
         sample_queue = {sample_queue, draw_sample(extreme_only)};
   endtask

   // Hold off until every sample is taken and every node is out, let the
   // pipeline empty, then pick new idling for the next phase.
   task automatic settle();
      while (sample_queue.size() != 0 || req_valid || pending_nodes.size() != 0)
         @(negedge clock);
      repeat (12) @(negedge clock);
      send_pace = pace_type'($urandom_range(0, 2));
      recv_pace = pace_type'($urandom_range(0, 2));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready)
            restrict_sample(req_fine_sample);
         if (!req_valid || req_ready) begin
            if (send_gap > 0 || sample_queue.size() == 0) begin
               if (send_gap > 0)
                  send_gap--;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_fine_sample <= sample_queue.pop_front();
               send_gap = draw_wait(send_pace);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_nodes.size() == 0) begin
               report_mismatch("transfer with no node pending", rsp_coarse_x, -1);
            end else begin
               oldest_node = pending_nodes.pop_front();
               if (rsp_coarse_value !== oldest_node.value)
                  report_mismatch("coarse_value", rsp_coarse_value, oldest_node.value);
               if (rsp_coarse_x !== oldest_node.x)
                  report_mismatch("coarse_x", rsp_coarse_x, oldest_node.x);
               if (rsp_coarse_y !== oldest_node.y)
                  report_mismatch("coarse_y", rsp_coarse_y, oldest_node.y);
               if (rsp_grid_done !== oldest_node.done)
                  report_mismatch("grid_done", rsp_grid_done, oldest_node.done);
            end
            rsp_stall = draw_wait(recv_pace);
         end
         if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      cfg_one_dim = 1'b0;
      cfg_width = 10'd512;
      cfg_height = 10'd512;
      cfg_defect = 1'b1;
      cfg_neumann = 1'b0;
      for (int k = 0; k < ROW_DEPTH; k++) begin
         row_above[k] = '0;
         row_above2[k] = '0;
      end
      for (int k = 0; k < 2; k++) begin
         cur_left[k] = '0;
         up_left[k] = '0;
         up2_left[k] = '0;
      end
      fine_x = 0;
      fine_y = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // sizes below the minimum act as two: corners only, doubled
      set_geometry(1'b0, 10'd1, 10'd0, 1'b1, 1'b1);
      sample_queue = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                       32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                       32'shFFFF_FFFF, 32'sh0000_0000, 32'sh0000_0001};
      settle();

      // line mode, defect interior unscaled sum at the negative extreme
      write_csr(CSR_ONE_DIM_MODE, CSR_DATA_BITS'(1));
      write_csr(CSR_COARSE_WIDTH, 10'd3);
      sample_queue = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                       32'sh8000_0000, 32'sh8000_0000};
      settle();

      // weighting change without restart; next line starts, then a partial one
      write_csr(CSR_DEFECT_MODE, CSR_DATA_BITS'(0));
      write_csr(CSR_NEUMANN_FIRST, CSR_DATA_BITS'(0));
      sample_queue = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                       32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
                       32'sh7FFF_FFFF};
      settle();

      // height write restarts the line even though line mode ignores it
      write_csr(CSR_COARSE_HEIGHT, 10'd2);
      sample_queue = '{32'shFFFF_FFFF, 32'sh0000_0001, 32'shFFFF_FFFF,
                       32'sh0000_0002, 32'sh8000_0001};
      settle();

      grid_items = 5;
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            // keep the grid position; only the weighting changes
            write_csr(CSR_DEFECT_MODE, CSR_DATA_BITS'($urandom_range(0, 1)));
            write_csr(CSR_NEUMANN_FIRST, CSR_DATA_BITS'($urandom_range(0, 1)));
         end else begin
            set_geometry($urandom_range(0, 3) == 0, draw_side(), draw_side(),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         case ($urandom_range(0, 4))
            0:       burst = $urandom_range(1, grid_items);
            1:       burst = 2 * grid_items;
            default: burst = grid_items;
         endcase
         // trim the last phase to the item budget
         if (burst > RANDOM_ITEMS - random_items)
            burst = RANDOM_ITEMS - random_items;
         load_samples(burst, $urandom_range(0, 4) == 0);
         random_items += burst;
         settle();
      end

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
